>>> sv/rid_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the run-length image decoder.
// No dependencies; imported by every rid_* module and the top level.
package rid_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int COUNT_BITS  = 14;
  localparam int RAW_BITS    = 16;

  localparam logic [7:0]  HEADER_BYTE0 = 8'h1A;
  localparam logic [7:0]  HEADER_BYTE1 = 8'h01;
  localparam logic [15:0] RUN_FLAG     = 16'h4000;
  localparam logic [15:0] RUN_MASK     = 16'h3FFF;
  localparam logic [LENGTH_BITS-1:0] MIN_LENGTH  = LENGTH_BITS'(7);
  localparam logic [LENGTH_BITS-1:0] TRAILER_LEN = LENGTH_BITS'(5);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_HEADER = 2'd2,
    ST_TRUNC  = 2'd3
  } status_t;

  typedef struct packed {
    logic                  out_valid;
    logic [7:0]            out_value;
    logic [COUNT_BITS-1:0] out_count;
    logic                  done_res;
    status_t               status;
  } result_t;

endpackage

>>> sv/rid_in_stage.sv
`timescale 1ns / 1ps
// Input register of the run-length image decoder: holds one compressed byte.
// Depends on rid_pkg.
module rid_in_stage import rid_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [7:0] data_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid;
  logic [7:0] byte_q;

  // Stall only while a byte is held and the decoder cannot take it
  assign req_stall  = valid && !take;
  assign held_valid = valid;
  assign held_byte  = byte_q;

  // Load a new request whenever the register is free or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!req_stall) begin
      valid <= req_valid;
    end
    if (req_valid && !req_stall) begin
      byte_q <= data_byte;
    end
  end

endmodule

>>> sv/rid_decode.sv
`timescale 1ns / 1ps
// Decode state machine: header check, command parsing, run and raw bytes.
// Depends on rid_pkg; one byte is decoded in the cycle it is taken.
module rid_decode import rid_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [LENGTH_BITS-1:0] stream_length,
  input  logic                   take,
  input  logic [7:0]             data_byte,
  output result_t                res
);

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_CMDHI, PH_CMDLO, PH_VALUE, PH_RAW, PH_SKIP
  } phase_t;

  phase_t                 phase, phase_next;
  logic [LENGTH_BITS-1:0] byte_position;
  logic [7:0]             command_high_byte, command_high_byte_next;
  logic [RAW_BITS-1:0]    raw_bytes_left, raw_bytes_left_next;
  logic [COUNT_BITS-1:0]  run_count, run_count_next;
  status_t                error_status, error_status_next;

  logic [RAW_BITS-1:0]    cmd;
  logic [LENGTH_BITS:0]   raw_end;
  logic [LENGTH_BITS:0]   trailer_start;
  logic [LENGTH_BITS-1:0] last_pos;
  logic                   short_len;
  logic                   at_last;

  assign cmd           = {command_high_byte, data_byte};
  assign raw_end       = {1'b0, byte_position} + (LENGTH_BITS+1)'(1)
                         + (LENGTH_BITS+1)'(cmd);
  assign trailer_start = {1'b0, byte_position} + {1'b0, TRAILER_LEN};
  assign last_pos      = stream_length - LENGTH_BITS'(1);
  assign short_len     = stream_length < MIN_LENGTH;
  assign at_last       = byte_position == last_pos;

  // Phase update and decoded data for the current byte
  always_comb begin
    phase_next             = phase;
    command_high_byte_next = command_high_byte;
    raw_bytes_left_next    = raw_bytes_left;
    run_count_next         = run_count;
    error_status_next      = error_status;
    res                    = '0;
    unique case (phase)
      PH_HDR0: begin
        if (short_len) begin
          error_status_next = ST_SHORT;
          phase_next        = PH_SKIP;
        end else if (data_byte != HEADER_BYTE0) begin
          error_status_next = ST_HEADER;
          phase_next        = PH_SKIP;
        end else begin
          phase_next = PH_HDR1;
        end
      end
      PH_HDR1: begin
        if (data_byte != HEADER_BYTE1) begin
          error_status_next = ST_HEADER;
          phase_next        = PH_SKIP;
        end else begin
          phase_next = PH_CMDHI;
        end
      end
      PH_CMDHI: begin
        // A command may start only ahead of the trailer
        if (trailer_start < {1'b0, stream_length}) begin
          command_high_byte_next = data_byte;
          phase_next             = PH_CMDLO;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_CMDLO: begin
        if ((cmd & RUN_FLAG) != '0) begin
          run_count_next = COUNT_BITS'(cmd & RUN_MASK);
          phase_next     = PH_VALUE;
        end else if (raw_end > {1'b0, stream_length}) begin
          error_status_next = ST_TRUNC;
          phase_next        = PH_SKIP;
        end else if (cmd == '0) begin
          phase_next = PH_CMDHI;
        end else begin
          raw_bytes_left_next = cmd;
          phase_next          = PH_RAW;
        end
      end
      PH_VALUE: begin
        if (run_count != '0) begin
          res.out_valid = 1'b1;
          res.out_value = data_byte;
          res.out_count = run_count;
        end
        phase_next = PH_CMDHI;
      end
      PH_RAW: begin
        res.out_valid       = 1'b1;
        res.out_value       = data_byte;
        res.out_count       = COUNT_BITS'(1);
        raw_bytes_left_next = raw_bytes_left - RAW_BITS'(1);
        if (raw_bytes_left_next == '0) begin
          phase_next = PH_CMDHI;
        end
      end
      default: begin
        phase_next = PH_SKIP;
      end
    endcase
    if (at_last) begin
      res.done_res = 1'b1;
      res.status   = short_len ? ST_SHORT : error_status_next;
    end
  end

  // Advance the job state on each taken byte; clear it after the last one
  always_ff @(posedge clk) begin
    if (rst || (take && at_last)) begin
      phase             <= PH_HDR0;
      byte_position     <= '0;
      command_high_byte <= '0;
      raw_bytes_left    <= '0;
      run_count         <= '0;
      error_status      <= ST_OK;
    end else if (take) begin
      phase             <= phase_next;
      byte_position     <= byte_position + LENGTH_BITS'(1);
      command_high_byte <= command_high_byte_next;
      raw_bytes_left    <= raw_bytes_left_next;
      run_count         <= run_count_next;
      error_status      <= error_status_next;
    end
  end

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    take && res.done_res |=> byte_position == '0 && phase == PH_HDR0)
    else $error("job state not cleared after last byte");

  a_raw_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_RAW |-> raw_bytes_left != '0)
    else $error("raw phase with no bytes left");

  a_data_phase: assert property (@(posedge clk) disable iff (rst)
    res.out_valid |-> phase == PH_VALUE || phase == PH_RAW)
    else $error("decoded data outside a data phase");

  a_status_done: assert property (@(posedge clk) disable iff (rst)
    res.status != ST_OK |-> res.done_res)
    else $error("status reported without done");

endmodule

>>> sv/rid_out_stage.sv
`timescale 1ns / 1ps
// Result register of the run-length image decoder.
// Depends on rid_pkg (result_t).
module rid_out_stage import rid_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load_valid,
  input  result_t load_res,
  output logic    load_ready,
  output logic    res_valid,
  input  logic    res_stall,
  output result_t res_q
);

  logic valid;

  // Free when empty or when the held request leaves this cycle
  assign load_ready = !valid || !res_stall;
  assign res_valid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ready) begin
      valid <= load_valid;
    end
    if (load_valid && load_ready) begin
      res_q <= load_res;
    end
  end

endmodule

>>> sv/rle_image_decompressor.sv
`timescale 1ns / 1ps
// Run-length image decompressor. Takes one compressed byte per cycle and
// gives one result per byte, at a sustained rate of one item per clock
// while res_stall is low; each byte passes the input register and is then
// decoded into the result register. Write stream_length (total bytes,
// header and trailer included) before a job; the config port is always
// ready. A result carries (out_value, out_count) when out_valid is set and
// done_res/status on the stream's last byte, after which a new job starts.
// Depends on rid_pkg, rid_in_stage, rid_decode and rid_out_stage.
module rle_image_decompressor import rid_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LENGTH_BITS-1:0] stream_length,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic [7:0]             data_byte,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic                   out_valid,
  output logic [7:0]             out_value,
  output logic [COUNT_BITS-1:0]  out_count,
  output logic                   done_res,
  output status_t                status
);

  logic [LENGTH_BITS-1:0] length_reg;
  logic                   held_valid;
  logic [7:0]             held_byte;
  logic                   load_ready;
  logic                   take;
  result_t                dec_res;
  result_t                res_q;

  // Hold the configured stream length
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      length_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      length_reg <= stream_length;
    end
  end

  assign take = held_valid && load_ready;

  rid_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .data_byte  (data_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  rid_decode u_dec (
    .clk           (clk),
    .rst           (rst),
    .stream_length (length_reg),
    .take          (take),
    .data_byte     (held_byte),
    .res           (dec_res)
  );

  rid_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (held_valid),
    .load_res   (dec_res),
    .load_ready (load_ready),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_q      (res_q)
  );

  assign out_valid = res_q.out_valid;
  assign out_value = res_q.out_value;
  assign out_count = res_q.out_count;
  assign done_res  = res_q.done_res;
  assign status    = res_q.status;

endmodule
